// ===== rtl/core/radar_blip_polar_mapper_top_defines.svh =====
// Assertion macros for the radar blip polar mapper.
`ifndef RADAR_BLIP_POLAR_MAPPER_TOP_DEFINES_SVH
`define RADAR_BLIP_POLAR_MAPPER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define RBPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RBPM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rbpm_pkg.sv =====
// Constants, widths and tables for the radar blip polar mapper.
`default_nettype none
package rbpm_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int SH = 32 - ANGLE_BITS;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = 25;
    localparam int SQ_W       = 49;
    localparam int SUM_W      = 50;
    localparam int SQRT_W     = 51;
    localparam int SQRT_ITERS = 25;
    localparam int DIST_W     = 25;
    localparam int RANGE_W    = 23;
    localparam int SCR_W      = 16;
    localparam int YAW_W      = 16;
    localparam int AV_W       = 52;
    localparam int RX_W       = 50;
    localparam int RZ_W       = 34;
    localparam int PROD_W     = RANGE_W + 32;

    localparam logic [31:0] INV_GAIN = 32'd2608131497;

    // pipeline stage numbers (stage 0 holds the differences)
    localparam int ST_SUM  = 2;
    localparam int ST_DIST = ST_SUM + SQRT_ITERS;
    localparam int ST_X0   = ST_DIST + 1;
    localparam int ST_ROT  = ST_X0 + 1;
    localparam int LAT     = ST_ROT + NS + 1;
    localparam int BRG_DLY = ST_X0 - (NS + 2);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 2'd2;

    localparam logic [RANGE_W-1:0] RANGE_RST = 23'd25600;
    localparam logic [SCR_W-1:0]   CX_RST    = 16'sd8000;
    localparam logic [SCR_W-1:0]   CY_RST    = -16'sd4000;

    // atan(2^-i) in 2^-32 turns
    localparam logic [31:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage
`default_nettype wire

// ===== rtl/core/radar_blip_polar_mapper_top.sv =====
// Radar blip polar mapper: distance, bearing and screen placement pipeline.
//
// Usage:
//   Input: drive the positions and camera_yaw and raise start; the item
//   transfers at a clock edge with start high and busy low. busy stays low,
//   so an item may transfer at every edge.
//   Output: o_valid is high for one cycle with o_blip_x / o_blip_y; the
//   receiver must take it then. Results leave in input order.
//   Each item passes through registered stages: differences, squares,
//   sum, square root, scale, rotation CORDIC and the output register.
//   Throughput: one item per cycle.
//   Latency is set by the 25 stage square root followed by the
//   rotation CORDIC, one stage per iteration.
//   Config: i_cfg_valid/o_cfg_ready write i_cfg_data to register
//   i_cfg_index (0 range_limit, 1 center_x, 2 center_y, 3 ignored);
//   ready is always high. Write only while no item is in flight.
//   Reset (i_rst_n low, synchronous) drops all items in flight and loads
//   range 100.0, center (500, -250) pixels.
`default_nettype none
`include "radar_blip_polar_mapper_top_defines.svh"
module radar_blip_polar_mapper_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [rbpm_pkg::COORD_W-1:0]   i_player_x,
    input  wire logic signed [rbpm_pkg::COORD_W-1:0]   i_player_y,
    input  wire logic signed [rbpm_pkg::COORD_W-1:0]   i_player_z,
    input  wire logic signed [rbpm_pkg::COORD_W-1:0]   i_target_x,
    input  wire logic signed [rbpm_pkg::COORD_W-1:0]   i_target_y,
    input  wire logic signed [rbpm_pkg::COORD_W-1:0]   i_target_z,
    input  wire logic        [rbpm_pkg::YAW_W-1:0]     i_camera_yaw,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic        [rbpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [rbpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                       o_valid,
    output logic signed      [rbpm_pkg::SCR_W-1:0]     o_blip_x,
    output logic signed      [rbpm_pkg::SCR_W-1:0]     o_blip_y
);
    import rbpm_pkg::*;

    logic                      acc;
    logic [LAT:0]              r_vld;
    logic [RANGE_W-1:0]        r_range_limit;
    logic signed [SCR_W-1:0]   r_center_x;
    logic signed [SCR_W-1:0]   r_center_y;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign acc         = start && !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_limit <= RANGE_RST;
            r_center_x    <= CX_RST;
            r_center_y    <= CY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RANGE_LIMIT: r_range_limit <= i_cfg_data;
                CFG_CENTER_X:    r_center_x    <= i_cfg_data[SCR_W-1:0];
                CFG_CENTER_Y:    r_center_y    <= i_cfg_data[SCR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:0], acc};
        end
    end

    // stage 0: differences
    logic signed [DIFF_W-1:0] r_ex, r_ey, r_ez;
    logic [YAW_W-1:0]         r_yaw0;

    always_ff @(posedge i_clk) begin
        r_ex   <= DIFF_W'(i_player_x) - DIFF_W'(i_target_x);
        r_ey   <= DIFF_W'(i_player_y) - DIFF_W'(i_target_y);
        r_ez   <= DIFF_W'(i_player_z) - DIFF_W'(i_target_z);
        r_yaw0 <= i_camera_yaw;
    end

    // stage 1: squares; stage 2: sum
    logic [SQ_W-1:0]     r_sqx, r_sqy, r_sqz;
    logic [2*DIFF_W-1:0] n_px, n_py, n_pz;

    assign n_px = (2*DIFF_W)'(r_ex * r_ex);
    assign n_py = (2*DIFF_W)'(r_ey * r_ey);
    assign n_pz = (2*DIFF_W)'(r_ez * r_ez);

    always_ff @(posedge i_clk) begin
        r_sqx <= n_px[SQ_W-1:0];
        r_sqy <= n_py[SQ_W-1:0];
        r_sqz <= n_pz[SQ_W-1:0];
    end

    // square root, one result bit per stage
    logic [SQRT_W-1:0] r_sv [0:SQRT_ITERS];
    logic [SQRT_W-1:0] r_sr [0:SQRT_ITERS];

    always_ff @(posedge i_clk) begin
        r_sv[0] <= SQRT_W'(r_sqx) + SQRT_W'(r_sqy) + SQRT_W'(r_sqz);
        r_sr[0] <= '0;
    end

    for (genvar j = 0; j < SQRT_ITERS; j++) begin : g_sqrt
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_ITERS - 1 - j));
        logic [SQRT_W-1:0] t;
        assign t = r_sr[j] + BIT;
        always_ff @(posedge i_clk) begin
            if (r_sv[j] >= t) begin
                r_sv[j+1] <= r_sv[j] - t;
                r_sr[j+1] <= (r_sr[j] >> 1) + BIT;
            end else begin
                r_sv[j+1] <= r_sv[j];
                r_sr[j+1] <= r_sr[j] >> 1;
            end
        end
    end

    // clamp and scale by 1/K
    logic [DIST_W-1:0]  root;
    logic [RANGE_W-1:0] clamped;
    logic [PROD_W-1:0]  prod;
    logic signed [RX_W-1:0] r_x0;

    assign root    = r_sr[SQRT_ITERS][DIST_W-1:0];
    assign clamped = (root > DIST_W'(r_range_limit)) ? r_range_limit
                                                      : root[RANGE_W-1:0];
    assign prod    = PROD_W'(clamped) * PROD_W'(INV_GAIN);

    always_ff @(posedge i_clk) begin
        r_x0 <= RX_W'(prod >> 8);
    end

    // vectoring CORDIC for atan2(ex, ez)
    logic signed [AV_W-1:0] r_ax [0:NS];
    logic signed [AV_W-1:0] r_ay [0:NS];
    logic [31:0]            r_az [0:NS];
    logic                   r_azero [0:NS];
    logic [YAW_W-1:0]       r_ayaw [0:NS];
    logic signed [AV_W-1:0] ix, iy;

    assign ix = AV_W'(r_ez) <<< 24;
    assign iy = AV_W'(r_ex) <<< 24;

    always_ff @(posedge i_clk) begin
        if (ix < 0) begin
            r_ax[0] <= -ix;
            r_ay[0] <= -iy;
            r_az[0] <= 32'h8000_0000;
        end else begin
            r_ax[0] <= ix;
            r_ay[0] <= iy;
            r_az[0] <= '0;
        end
        r_azero[0] <= (r_ex == '0) && (r_ez == '0);
        r_ayaw[0]  <= r_yaw0;
    end

    for (genvar m = 0; m < NS; m++) begin : g_atan
        always_ff @(posedge i_clk) begin
            if (r_ay[m] >= 0) begin
                r_ax[m+1] <= r_ax[m] + (r_ay[m] >>> m);
                r_ay[m+1] <= r_ay[m] - (r_ax[m] >>> m);
                r_az[m+1] <= r_az[m] + ATAN_TURNS[m];
            end else begin
                r_ax[m+1] <= r_ax[m] - (r_ay[m] >>> m);
                r_ay[m+1] <= r_ay[m] + (r_ax[m] >>> m);
                r_az[m+1] <= r_az[m] - ATAN_TURNS[m];
            end
            r_azero[m+1] <= r_azero[m];
            r_ayaw[m+1]  <= r_ayaw[m];
        end
    end

    // bearing, rounded to ANGLE_BITS, then delayed to meet the distance
    logic [31:0]           bsum, bround;
    logic [ANGLE_BITS-1:0] r_brg [0:BRG_DLY];

    assign bsum   = (r_azero[NS] ? 32'h0 : r_az[NS]) + 32'h4000_0000
                    - {r_ayaw[NS], 16'h0};
    assign bround = bsum + (32'h1 << (SH - 1));

    always_ff @(posedge i_clk) begin
        r_brg[0] <= bround[SH +: ANGLE_BITS];
    end

    for (genvar k = 0; k < BRG_DLY; k++) begin : g_bdly
        always_ff @(posedge i_clk) begin
            r_brg[k+1] <= r_brg[k];
        end
    end

    // rotation CORDIC
    logic signed [RX_W-1:0] r_rx [0:NS];
    logic signed [RX_W-1:0] r_ry [0:NS];
    logic signed [RZ_W-1:0] r_rz [0:NS];
    logic [31:0]            zb;
    logic signed [RZ_W-1:0] z0;

    assign zb = {r_brg[BRG_DLY], {SH{1'b0}}};
    assign z0 = $signed({{(RZ_W-32){zb[31]}}, zb});

    always_ff @(posedge i_clk) begin
        r_ry[0] <= '0;
        if (z0 > $signed(RZ_W'(32'h4000_0000))) begin
            r_rx[0] <= -r_x0;
            r_rz[0] <= z0 - $signed(RZ_W'(32'h8000_0000));
        end else if (z0 < -$signed(RZ_W'(32'h4000_0000))) begin
            r_rx[0] <= -r_x0;
            r_rz[0] <= z0 + $signed(RZ_W'(32'h8000_0000));
        end else begin
            r_rx[0] <= r_x0;
            r_rz[0] <= z0;
        end
    end

    for (genvar n = 0; n < NS; n++) begin : g_rot
        localparam logic signed [RZ_W-1:0] AT = RZ_W'(ATAN_TURNS[n]);
        always_ff @(posedge i_clk) begin
            if (r_rz[n] >= 0) begin
                r_rx[n+1] <= r_rx[n] - (r_ry[n] >>> n);
                r_ry[n+1] <= r_ry[n] + (r_rx[n] >>> n);
                r_rz[n+1] <= r_rz[n] - AT;
            end else begin
                r_rx[n+1] <= r_rx[n] + (r_ry[n] >>> n);
                r_ry[n+1] <= r_ry[n] - (r_rx[n] >>> n);
                r_rz[n+1] <= r_rz[n] + AT;
            end
        end
    end

    // round to Q12.4, add center, saturate
    localparam int OFS_W = RX_W - 28;
    localparam int POS_W = OFS_W + 1;
    logic signed [RX_W-1:0]  rxr, ryr;
    logic signed [OFS_W-1:0] ofx, ofy;
    logic signed [POS_W-1:0] px, py;
    logic signed [SCR_W-1:0] r_bx, r_by;

    assign rxr = r_rx[NS] + $signed(RX_W'(1) <<< 27);
    assign ryr = r_ry[NS] + $signed(RX_W'(1) <<< 27);
    assign ofx = OFS_W'(rxr >>> 28);
    assign ofy = OFS_W'(ryr >>> 28);
    assign px  = POS_W'(ofx) + POS_W'(r_center_x);
    assign py  = POS_W'(ofy) + POS_W'(r_center_y);

    function automatic logic signed [SCR_W-1:0] sat(input logic signed [POS_W-1:0] v);
        logic signed [POS_W-1:0] hi, lo;
        hi = POS_W'(32767);
        lo = -POS_W'(32768);
        if (v > hi)      sat = 16'sh7FFF;
        else if (v < lo) sat = 16'sh8000;
        else             sat = v[SCR_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        r_bx <= sat(px);
        r_by <= sat(py);
    end

    assign o_valid  = r_vld[LAT];
    assign o_blip_x = r_bx;
    assign o_blip_y = r_by;

    localparam logic signed [RZ_W-1:0] QTR = RZ_W'(32'h4000_0000);
    logic rz0_ok;

    assign rz0_ok = (r_rz[0] <= QTR) && (r_rz[0] >= -QTR);

    `RBPM_ASSERT_IMP(a_latency, o_valid, $past(acc, LAT + 1), "result without matching transfer")
    `RBPM_ASSERT_NXT(a_prerot, r_vld[ST_X0], rz0_ok, "rotation start angle outside quarter turn")
    `RBPM_ASSERT_IMP(a_zero_range, r_vld[ST_X0] && (r_range_limit == '0), r_x0 == '0, "zero range")

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the radar blip polar mapper.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rbpm_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [COORD_W-1:0] px = '0, py = '0, pz = '0, tx = '0, ty = '0, tz = '0;
    logic [YAW_W-1:0] yaw = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_valid;
    logic signed [SCR_W-1:0] o_blip_x, o_blip_y;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    radar_blip_polar_mapper_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_player_x(px), .i_player_y(py), .i_player_z(pz),
        .i_target_x(tx), .i_target_y(ty), .i_target_z(tz),
        .i_camera_yaw(yaw), .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_blip_x(o_blip_x), .o_blip_y(o_blip_y)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    typedef struct packed {
        logic signed [15:0] bx;
        logic signed [15:0] by;
    } t_blip;

    t_blip blip_q[$];
    int unsigned errors = 0;
    longint unsigned cycles = 0;

    // predictor's own copy of the registers
    logic [RANGE_W-1:0] range_lim = 23'd25600;
    logic signed [15:0] cen_x = 16'sd8000;
    logic signed [15:0] cen_y = -16'sd4000;

    localparam logic [31:0] ATAN_TAB [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };
    localparam int N_STG = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // vectoring CORDIC: angle of (ez, ex) as 32-bit binary angle
    function automatic logic [31:0] vec_angle(longint ex, longint ez);
        longint x, y, xs, ys;
        logic [31:0] z;
        x = ez <<< 24;
        y = ex <<< 24;
        z = '0;
        if (ex == 0 && ez == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < N_STG; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic logic signed [15:0] sat_px(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return -16'sh8000;
        return v[15:0];
    endfunction

    function automatic t_blip place_blip(logic signed [23:0] a_x, a_y, a_z, b_x, b_y, b_z,
                                         logic [15:0] cam);
        longint ex, ey, ez, x, y, z, xs, ys;
        longint unsigned rad;
        logic [31:0] brg;
        logic [32:0] rnd;
        t_blip r;
        ex = longint'(a_x) - longint'(b_x);
        ey = longint'(a_y) - longint'(b_y);
        ez = longint'(a_z) - longint'(b_z);
        rad = int_sqrt(longint'(ex * ex + ey * ey + ez * ez));
        if (rad > range_lim) rad = range_lim;
        brg = vec_angle(ex, ez) + 32'h40000000 - {cam, 16'h0};
        rnd = {1'b0, brg} + (33'd1 << (SH - 1));
        brg = (rnd[31:0] >> SH) << SH;
        z = longint'($signed(brg));
        x = longint'((rad * 64'd2608131497) >> 8);
        y = 0;
        if (z > 64'sh40000000) begin
            x = -x; z -= 64'sh80000000;
        end else if (z < -64'sh40000000) begin
            x = -x; z += 64'sh80000000;
        end
        for (int i = 0; i < N_STG; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z -= longint'(ATAN_TAB[i]);
            end else begin
                x = x + ys; y = y - xs; z += longint'(ATAN_TAB[i]);
            end
        end
        x = (x + (64'sd1 <<< 27)) >>> 28;
        y = (y + (64'sd1 <<< 27)) >>> 28;
        r.bx = sat_px(longint'(cen_x) + x);
        r.by = sat_px(longint'(cen_y) + y);
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_blip e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (blip_q.size() == 0) begin
                $error("unexpected blip x=%0d y=%0d", o_blip_x, o_blip_y);
                errors++;
            end else begin
                e = blip_q.pop_front();
                if (o_blip_x !== e.bx) begin
                    $error("blip_x expected %0d actual %0d", e.bx, o_blip_x);
                    errors++;
                end
                if (o_blip_y !== e.by) begin
                    $error("blip_y expected %0d actual %0d", e.by, o_blip_y);
                    errors++;
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycles > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    bit gaps_on = 1'b1;

    task automatic send_blip(logic signed [23:0] a_x, a_y, a_z, b_x, b_y, b_z,
                             logic [15:0] cam);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        px <= a_x; py <= a_y; pz <= a_z;
        tx <= b_x; ty <= b_y; tz <= b_z;
        yaw <= cam;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        blip_q.push_back(place_blip(a_x, a_y, a_z, b_x, b_y, b_z, cam));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (blip_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_RANGE_LIMIT: range_lim = val;
            CFG_CENTER_X:    cen_x = val[15:0];
            CFG_CENTER_Y:    cen_y = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic signed [23:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 8000)) - 4000);
            2: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
            default: return 24'($signed($urandom_range(0, 100000)) - 50000);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [23:0] mx, mn;
        mx = 24'sh7FFFFF;
        mn = -24'sh800000;
        send_blip(0, 0, 0, 0, 0, 0, 0);              // coincident
        send_blip(0, 500, 0, 0, 0, 0, 16'h4000);      // coincident in x/z, dy only
        send_blip(mx, mx, mx, mn, mn, mn, 16'hFFFF);
        send_blip(mn, mn, mn, mx, mx, mx, 16'h8000);
        send_blip(2560, 0, 0, 0, 0, 0, 0);
        send_blip(-2560, 0, 0, 0, 0, 0, 0);
        send_blip(0, 0, 2560, 0, 0, 0, 0);
        send_blip(0, 0, -2560, 0, 0, 0, 0);
        send_blip(0, 0, -2560, 0, 0, 1, 16'h0001);
        send_blip(1280, -300, 1280, 0, 0, 0, 16'h2000);
        send_blip(mx, 0, mn, 0, 0, 0, 16'hC000);
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_blip(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                      rnd_coord(), 16'($urandom));
        drain();
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_RANGE_LIMIT, '0);   // every blip on the center
        write_reg(CFG_CENTER_X, 23'h7FFF);
        write_reg(CFG_CENTER_Y, 23'h8000);
        test_random(100);
        write_reg(CFG_RANGE_LIMIT, 23'h7FFFFF);
        write_reg(CFG_CENTER_X, 23'h8000);
        write_reg(CFG_CENTER_Y, 23'h7FFF);
        write_reg(CFG_UNUSED, 23'h12345);
        test_random(250);
        write_reg(CFG_RANGE_LIMIT, 23'd3000);
        write_reg(CFG_CENTER_X, 23'($urandom));
        write_reg(CFG_CENTER_Y, 23'($urandom));
        gaps_on = 1'b0;                  // back-to-back
        test_random(200);
        gaps_on = 1'b1;
        write_reg(CFG_RANGE_LIMIT, 23'd25600);
        write_reg(CFG_CENTER_X, 23'd8000);
        write_reg(CFG_CENTER_Y, 23'h7FFFFF & 23'(-16'sd4000));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(350);
        test_config_sweep();
        test_random(350);
        if (errors == 0 && blip_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rbpm_pkg.sv
rtl/core/radar_blip_polar_mapper_top.sv
sim/tb_top.sv
